@@ src/vnd_pkg.sv @@
package vnd_pkg;

  // Field widths of the result item and of the per-code state.
  localparam int FIRST_W  = 34;
  localparam int SECOND_W = 36;
  localparam int COUNT_W  = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ILLEGAL  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Top two bits of a coded byte.
  localparam logic [1:0] TOP_ILLEGAL = 2'b11;

  // Depth of the queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 2;

  // What the front decided about one byte.
  typedef enum logic [1:0] {
    KIND_MORE,
    KIND_CLOSE,
    KIND_ILLEGAL
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       pair;
    logic [6:0] bits;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

@@ src/vnd_byte_if.sv @@
interface vnd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ src/vnd_result_if.sv @@
interface vnd_result_if;
  logic        valid;
  logic        ready;
  logic [33:0] main_value;
  logic [35:0] second_value;
  logic [1:0]  status;

  modport source (output valid, output main_value, output second_value, output status,
                  input ready);
  modport sink (input valid, input main_value, input second_value, input status,
                output ready);
endinterface

@@ src/vnd_cfg_if.sv @@
interface vnd_cfg_if;
  logic valid;
  logic ready;
  logic format_mode;

  modport source (output valid, output format_mode, input ready);
  modport sink (input valid, input format_mode, output ready);
endinterface

@@ src/vnd_front.sv @@
module vnd_front (
  input  logic             clk,
  input  logic             rst_n,
  vnd_byte_if.sink         in_bytes,
  vnd_cfg_if.sink          cfg_wr,
  input  logic             queue_full,
  output vnd_pkg::push_t   push
);

  logic mode_r;
  logic mode_nxt;

  assign cfg_wr.ready = 1'b1;
  assign mode_nxt = (cfg_wr.valid && cfg_wr.ready) ? cfg_wr.format_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign in_bytes.ready = !queue_full;

  // The mode is sampled with each byte, so every byte carries its own mode.
  always_comb begin
    push.valid      = in_bytes.valid && in_bytes.ready;
    push.entry.pair = mode_r;
    push.entry.bits = in_bytes.byte_in[6:0];
    if (in_bytes.byte_in[7:6] == vnd_pkg::TOP_ILLEGAL) begin
      push.entry.kind = vnd_pkg::KIND_ILLEGAL;
    end else if (in_bytes.byte_in[7]) begin
      push.entry.kind = vnd_pkg::KIND_CLOSE;
    end else begin
      push.entry.kind = vnd_pkg::KIND_MORE;
    end
  end

endmodule

@@ src/vnd_queue.sv @@
module vnd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  vnd_pkg::push_t   push,
  output logic             full,
  output logic             out_valid,
  output vnd_pkg::entry_t  out_entry,
  input  logic             pop
);

  localparam int DEPTH = vnd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vnd_pkg::entry_t  store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_FULL);
  assign out_valid = (count_r != '0);
  assign out_entry = store_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && out_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

@@ src/vnd_back.sv @@
module vnd_back #(
  parameter int MAX_NUMBER_BYTES = 5,
  parameter int MAX_PAIR_BYTES   = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  vnd_pkg::entry_t  q_entry,
  output logic             q_pop,
  vnd_result_if.source     out_result
);

  localparam int FW = vnd_pkg::FIRST_W;
  localparam int SW = vnd_pkg::SECOND_W;
  localparam int CW = vnd_pkg::COUNT_W;
  localparam logic [CW:0] NUMBER_LIMIT = (CW+1)'(MAX_NUMBER_BYTES);
  localparam logic [CW:0] PAIR_LIMIT   = (CW+1)'(MAX_PAIR_BYTES);

  logic [FW-1:0] first_r;
  logic [FW-1:0] first_nxt;
  logic [SW-1:0] second_r;
  logic [SW-1:0] second_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] count_inc;
  logic [FW-1:0] first_acc;
  logic [SW-1:0] second_acc;
  logic          too_long;

  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [FW-1:0] main_r;
  logic [FW-1:0] main_nxt;
  logic [SW-1:0] sec_r;
  logic [SW-1:0] sec_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic          out_free;

  // The output register takes a new result whenever it is empty or being drained.
  assign out_free = !out_valid_r || out_result.ready;
  assign q_pop    = q_valid && out_free;

  assign count_inc = (count_r == vnd_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;

  // Shift-and-or accumulation, trimmed to the accumulator widths.
  always_comb begin
    first_acc  = first_r;
    second_acc = second_r;
    if (q_entry.pair) begin
      if (q_entry.kind == vnd_pkg::KIND_CLOSE) begin
        first_acc = {first_r[FW-3:0], q_entry.bits[5:4]};
      end else begin
        first_acc = {first_r[FW-4:0], q_entry.bits[6:4]};
      end
      second_acc = {second_r[SW-5:0], q_entry.bits[3:0]};
    end else begin
      if (q_entry.kind == vnd_pkg::KIND_CLOSE) begin
        first_acc = {first_r[FW-7:0], q_entry.bits[5:0]};
      end else begin
        first_acc = {first_r[FW-8:0], q_entry.bits[6:0]};
      end
    end
    too_long = {1'b0, count_inc} > (q_entry.pair ? PAIR_LIMIT : NUMBER_LIMIT);
  end

  always_comb begin
    first_nxt     = first_r;
    second_nxt    = second_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_result.ready;
    main_nxt      = main_r;
    sec_nxt       = sec_r;
    status_nxt    = status_r;
    if (q_pop) begin
      unique case (q_entry.kind)
        vnd_pkg::KIND_MORE: begin
          first_nxt  = first_acc;
          second_nxt = second_acc;
          count_nxt  = count_inc;
        end
        vnd_pkg::KIND_CLOSE: begin
          first_nxt     = '0;
          second_nxt    = '0;
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          if (too_long) begin
            main_nxt   = '0;
            sec_nxt    = '0;
            status_nxt = vnd_pkg::STATUS_TOO_LONG;
          end else begin
            main_nxt   = first_acc;
            sec_nxt    = q_entry.pair ? second_acc : '0;
            status_nxt = vnd_pkg::STATUS_OK;
          end
        end
        vnd_pkg::KIND_ILLEGAL: begin
          first_nxt     = '0;
          second_nxt    = '0;
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          main_nxt      = '0;
          sec_nxt       = '0;
          status_nxt    = vnd_pkg::STATUS_ILLEGAL;
        end
        default: begin
          first_nxt = first_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      second_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r   <= main_nxt;
    sec_r    <= sec_nxt;
    status_r <= status_nxt;
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.main_value   = main_r;
  assign out_result.second_value = sec_r;
  assign out_result.status       = status_r;

  a_illegal_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.kind == vnd_pkg::KIND_ILLEGAL)
      |=> (out_valid_r && status_r == vnd_pkg::STATUS_ILLEGAL && count_r == '0))
    else $error("illegal byte did not give an illegal result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != vnd_pkg::STATUS_OK) |-> (main_r == '0 && sec_r == '0))
    else $error("error result carries nonzero values");

  a_no_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_result.ready) |-> !q_pop)
    else $error("entry taken while result is held");

endmodule

@@ src/varint_number_pair_decoder.sv @@
// Channel     Direction  Handshake     Payload
// in_bytes    in         valid/ready   byte_in[7:0]
// out_result  out        valid/ready   main_value[33:0], second_value[35:0], status[1:0]
// cfg_wr      in         valid/ready   format_mode (ready is always high)
//
// One byte is taken every clock cycle when the result side keeps up.
// A result is presented once its closing or illegal byte has been taken,
// has waited in the front-to-back queue and has then been loaded into the
// output register, from which it can be taken.
// rst_n is synchronous and active low; it clears the mode, the queue and the
// code being built. If out_result stalls, the two-entry queue fills and then
// in_bytes.ready drops until the held result is taken.
module varint_number_pair_decoder #(
  parameter int MAX_NUMBER_BYTES = 5,
  parameter int MAX_PAIR_BYTES   = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  vnd_byte_if.sink      in_bytes,
  vnd_cfg_if.sink       cfg_wr,
  vnd_result_if.source  out_result
);

  // The front holds the mode register and sorts each byte into more data,
  // a closing byte or an illegal byte, tagging it with the current mode.
  vnd_pkg::push_t  push;
  logic            queue_full;

  // The queue lets the front keep taking bytes while the back is stalled by
  // a result that has not yet been taken.
  logic            q_valid;
  vnd_pkg::entry_t q_entry;
  logic            q_pop;

  vnd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bytes   (in_bytes),
    .cfg_wr     (cfg_wr),
    .queue_full (queue_full),
    .push       (push)
  );

  vnd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (queue_full),
    .out_valid (q_valid),
    .out_entry (q_entry),
    .pop       (q_pop)
  );

  // The back accumulates the code and fills the output register. The byte
  // count saturates at fifteen, and a closing byte whose count exceeds the
  // limit of its mode reports a code that is too long with zero values.
  vnd_back #(
    .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES),
    .MAX_PAIR_BYTES   (MAX_PAIR_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_result (out_result)
  );

endmodule
